FILE: hdl/msgm_pkg.sv
// ----------------------------------------------------------------------------
// msgm_pkg: shared types and constants of the mark/space glitch merger
// Duration width, merge rules, item layout, register codes and the
// saturating three-way duration sum.
// ----------------------------------------------------------------------------
package msgm_pkg;

  localparam int DURATION_BITS = 16;
  localparam int STAGES        = 4;

  typedef logic [DURATION_BITS-1:0] dur_t;

  localparam dur_t DURATION_MAX      = '1;
  localparam dur_t SHORT_LIMIT_RESET = dur_t'(15);
  localparam dur_t LONG_LIMIT_RESET  = dur_t'(1440);

  typedef enum logic [1:0] {
    RULE_SHORT_GAP,
    RULE_SHORT_MARK,
    RULE_LONG_MARK,
    RULE_ISOLATED_MARK
  } rule_t;

  // codes beyond the two limit registers are ignored on write
  typedef enum logic [1:0] {
    CFG_SHORT_LIMIT,
    CFG_LONG_LIMIT
  } cfg_reg_t;

  // cause: set when the item travels as part of a block-end flush
  typedef struct packed {
    logic mark;
    logic last;
    logic cause;
    dur_t len;
  } item_t;

  localparam rule_t STAGE_RULE [STAGES] = '{
    RULE_SHORT_GAP, RULE_SHORT_MARK, RULE_LONG_MARK, RULE_ISOLATED_MARK
  };

  function automatic dur_t sat_sum3(dur_t a, dur_t b, dur_t c);
    logic [DURATION_BITS+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return (s > {2'b00, DURATION_MAX}) ? DURATION_MAX : s[DURATION_BITS-1:0];
  endfunction

endpackage

FILE: hdl/msgm_stage.sv
// ----------------------------------------------------------------------------
// msgm_stage: one merge pass
// Holds an accumulated item and one lookahead item, merges the lookahead and
// the incoming item into the accumulator when the stage rule hits, and
// drains its contents one transaction per cycle, unless stalled, at block end.
// ----------------------------------------------------------------------------
module msgm_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  msgm_pkg::rule_t               rule,
  input  logic [msgm_pkg::DURATION_BITS-1:0] short_limit,
  input  logic [msgm_pkg::DURATION_BITS-1:0] long_limit,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  msgm_pkg::item_t               in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output msgm_pkg::item_t               out_item
);
  import msgm_pkg::*;

  item_t held, held_next;
  logic  held_valid, held_valid_next;
  item_t look, look_next;
  logic  look_valid, look_valid_next;
  dur_t  prior, prior_next;
  logic  flushing, flushing_next;
  logic  out_valid_next;
  item_t out_item_next;

  logic emit_ok;
  logic accept;
  logic look_short;
  logic look_long;
  logic merge_hit;
  logic out_load;

  assign emit_ok  = !out_valid || out_ready;
  assign in_ready = emit_ok && !flushing;
  assign accept   = in_valid && in_ready;

  assign look_short = look.len < short_limit;
  assign look_long  = look.len > long_limit;

  always_comb begin
    unique case (rule)
      RULE_SHORT_GAP:  merge_hit = !look.mark && look_short;
      RULE_SHORT_MARK: merge_hit = look.mark && look_short;
      RULE_LONG_MARK:  merge_hit = look.mark && look_long;
      RULE_ISOLATED_MARK: begin
        merge_hit = look.mark && (prior > long_limit) && (in_item.len > long_limit);
      end
      default:         merge_hit = 1'b0;
    endcase
  end

  always_comb begin
    held_next       = held;
    held_valid_next = held_valid;
    look_next       = look;
    look_valid_next = look_valid;
    prior_next      = prior;
    flushing_next   = flushing;
    out_load        = 1'b0;
    out_item_next   = out_item;

    if (flushing) begin
      // drain accumulator first, then lookahead
      if (emit_ok) begin
        out_load = 1'b1;
        if (held_valid) begin
          out_item_next       = held;
          out_item_next.cause = 1'b1;
          held_valid_next     = 1'b0;
          flushing_next       = look_valid;
        end else begin
          out_item_next       = look;
          out_item_next.cause = 1'b1;
          look_valid_next     = 1'b0;
          flushing_next       = 1'b0;
        end
      end
    end else if (accept) begin
      flushing_next = in_item.last;
      if (!held_valid) begin
        held_next       = in_item;
        held_valid_next = 1'b1;
        prior_next      = in_item.len;
      end else if (!look_valid) begin
        look_next       = in_item;
        look_valid_next = 1'b1;
      end else if (merge_hit) begin
        held_next.len   = sat_sum3(held.len, look.len, in_item.len);
        held_next.last  = in_item.last;
        look_valid_next = 1'b0;
        prior_next      = in_item.len;
      end else begin
        out_load            = 1'b1;
        out_item_next       = held;
        out_item_next.cause = in_item.cause;
        held_next           = look;
        prior_next          = look.len;
        look_next           = in_item;
      end
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      look_valid <= 1'b0;
      flushing   <= 1'b0;
      out_valid  <= 1'b0;
      prior      <= '0;
    end else begin
      held_valid <= held_valid_next;
      look_valid <= look_valid_next;
      flushing   <= flushing_next;
      out_valid  <= out_valid_next;
      prior      <= prior_next;
    end
    held     <= held_next;
    look     <= look_next;
    out_item <= out_item_next;
  end

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.last |=> flushing)
    else $error("block end did not start a flush");

  a_flush_has_content: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (held_valid || look_valid))
    else $error("flushing with nothing held");

  // during a drain the lookahead can outlive the accumulator
  a_look_needs_held: assert property (@(posedge clk) disable iff (rst)
    look_valid && !flushing |-> held_valid)
    else $error("lookahead valid without accumulator");

endmodule

FILE: hdl/mark_space_glitch_merger.sv
// ----------------------------------------------------------------------------
// mark_space_glitch_merger: four chained glitch merge passes
// Merges short gaps, short marks, long marks and isolated marks in a stream
// of key mark/space durations, with saturating sums.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   input   | in_valid / in_ready  | is_mark, length_ms, block_last
//   result  | out_valid / out_ready| out_mark, out_length, out_block_last,
//           |                      | run_last
//   config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input transaction per cycle while results keep flowing and the first
// pass is not draining; an item that is not the end of a block yields at
// most one result. Each pass sits behind its own output register, so a
// result passes through the output register of every pass before it is valid.
// A block-end item makes each pass drain up to two held items, one per
// cycle while its output is free; that pass takes no input while it drains.
// Synchronous reset empties all passes and loads the default limits.
// A stall on the result side backs up pass by pass to in_ready.
// ----------------------------------------------------------------------------
module mark_space_glitch_merger (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               is_mark,
  input  logic [msgm_pkg::DURATION_BITS-1:0] length_ms,
  input  logic                               block_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_mark,
  output logic [msgm_pkg::DURATION_BITS-1:0] out_length,
  output logic                               out_block_last,
  output logic                               run_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  msgm_pkg::cfg_reg_t                 cfg_index,
  input  logic [msgm_pkg::DURATION_BITS-1:0] cfg_data
);
  import msgm_pkg::*;

  dur_t short_limit;
  dur_t long_limit;

  item_t link_item  [STAGES+1];
  logic  link_valid [STAGES+1];
  logic  link_ready [STAGES+1];

  // Config registers: always ready, writes land immediately.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit <= SHORT_LIMIT_RESET;
      long_limit  <= LONG_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHORT_LIMIT: short_limit <= cfg_data;
        CFG_LONG_LIMIT:  long_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Feed the first pass; a block-end item starts a flush, so tag it as such.
  assign link_valid[0]      = in_valid;
  assign in_ready           = link_ready[0];
  assign link_item[0].mark  = is_mark;
  assign link_item[0].last  = block_last;
  assign link_item[0].cause = block_last;
  assign link_item[0].len   = length_ms;

  for (genvar k = 0; k < STAGES; k++) begin : g_pass
    msgm_stage u_pass (
      .clk         (clk),
      .rst         (rst),
      .rule        (STAGE_RULE[k]),
      .short_limit (short_limit),
      .long_limit  (long_limit),
      .in_valid    (link_valid[k]),
      .in_ready    (link_ready[k]),
      .in_item     (link_item[k]),
      .out_valid   (link_valid[k+1]),
      .out_ready   (link_ready[k+1]),
      .out_item    (link_item[k+1])
    );
  end

  // The last pass's output register is the result register.
  assign out_valid          = link_valid[STAGES];
  assign link_ready[STAGES] = out_ready;
  assign out_mark           = link_item[STAGES].mark;
  assign out_length         = link_item[STAGES].len;
  assign out_block_last     = link_item[STAGES].last;
  // A result outside a flush is the only one its item causes; inside a
  // flush only the block-end result closes the run.
  assign run_last = !link_item[STAGES].cause || link_item[STAGES].last;

  a_block_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_block_last |-> run_last)
    else $error("block end result does not close its run");

endmodule
